// File: hdl/assert_macros.svh
// Assertion macros for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check prop at every rising clock edge while reset is released.
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check prop at every rising clock edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// File: hdl/cigar_pkg.sv
// Types, character codes, op codes and decode functions of the CIGAR encoder.
package cigar_pkg;

  localparam logic [7:0] CH_0    = 8'h30;
  localparam logic [7:0] CH_9    = 8'h39;
  localparam logic [7:0] CH_M    = 8'h4D;
  localparam logic [7:0] CH_I    = 8'h49;
  localparam logic [7:0] CH_D    = 8'h44;
  localparam logic [7:0] CH_N    = 8'h4E;
  localparam logic [7:0] CH_S    = 8'h53;
  localparam logic [7:0] CH_H    = 8'h48;
  localparam logic [7:0] CH_P    = 8'h50;
  localparam logic [7:0] CH_EQ   = 8'h3D;
  localparam logic [7:0] CH_X    = 8'h58;
  localparam logic [7:0] CH_STAR = 8'h2A;

  localparam logic [5:0] OP_M       = 6'd0;
  localparam logic [5:0] OP_I       = 6'd1;
  localparam logic [5:0] OP_D       = 6'd2;
  localparam logic [5:0] OP_N       = 6'd3;
  localparam logic [5:0] OP_S       = 6'd4;
  localparam logic [5:0] OP_H       = 6'd5;
  localparam logic [5:0] OP_P       = 6'd6;
  localparam logic [5:0] OP_EQ      = 6'd7;
  localparam logic [5:0] OP_X       = 6'd8;
  localparam logic [5:0] OP_UNKNOWN = 6'd42;

  localparam logic [27:0] LEN_MAX = 28'h0FFFFFFF;

  // Bin offsets of the five finer reg2bin levels, finest first; the coarsest bin is 0.
  localparam int unsigned BIN_OFS_14 = ((1 << 15) - 1) / 7;
  localparam int unsigned BIN_OFS_17 = ((1 << 12) - 1) / 7;
  localparam int unsigned BIN_OFS_20 = ((1 << 9) - 1) / 7;
  localparam int unsigned BIN_OFS_23 = ((1 << 6) - 1) / 7;
  localparam int unsigned BIN_OFS_26 = ((1 << 3) - 1) / 7;

  typedef struct packed {
    logic [5:0] code;
    logic       adv;
  } op_info_t;

  typedef struct packed {
    logic        is_summary;
    logic [31:0] op_word;
    logic [15:0] op_count;
    logic [15:0] bin;
    logic [31:0] end_pos;
    logic        last_of_run;
  } res_t;

  function automatic op_info_t op_decode(input logic [7:0] ch);
    op_info_t r;
    r.adv = 1'b0;
    case (ch)
      CH_M: begin
        r.code = OP_M;
        r.adv  = 1'b1;
      end
      CH_I: r.code = OP_I;
      CH_D: begin
        r.code = OP_D;
        r.adv  = 1'b1;
      end
      CH_N: begin
        r.code = OP_N;
        r.adv  = 1'b1;
      end
      CH_S: r.code = OP_S;
      CH_H: r.code = OP_H;
      CH_P: begin
        r.code = OP_P;
        r.adv  = 1'b1;
      end
      CH_EQ: begin
        r.code = OP_EQ;
        r.adv  = 1'b1;
      end
      CH_X: begin
        r.code = OP_X;
        r.adv  = 1'b1;
      end
      default: r.code = OP_UNKNOWN;
    endcase
    return r;
  endfunction

  // reg2bin of [beg, fin); an empty span is taken as [beg, beg+1).
  function automatic logic [15:0] bin_of(input logic [30:0] beg, input logic [31:0] fin);
    logic [31:0] b;
    logic [31:0] e;
    logic [31:0] r;
    b = {1'b0, beg};
    e = (fin > b) ? fin - 32'd1 : b;
    if ((b >> 14) == (e >> 14))      r = 32'(BIN_OFS_14) + (b >> 14);
    else if ((b >> 17) == (e >> 17)) r = 32'(BIN_OFS_17) + (b >> 17);
    else if ((b >> 20) == (e >> 20)) r = 32'(BIN_OFS_20) + (b >> 20);
    else if ((b >> 23) == (e >> 23)) r = 32'(BIN_OFS_23) + (b >> 23);
    else if ((b >> 26) == (e >> 26)) r = 32'(BIN_OFS_26) + (b >> 26);
    else                             r = 32'd0;
    return r[15:0];
  endfunction

endpackage

// File: hdl/cigar_text_to_binary_ops_with_bin.sv
// CIGAR text to binary op words, with end position and reg2bin bin per record.
//
//  channel | dir | tdata                                   | tuser      | tlast
//  in_     | in  | ch[7:0], start_pos[38:8], pad[39]       | first      | last
//  out_    | out | op_word, op_count, bin, end_pos (96b)   | is_summary | last_of_run
//
// One character is taken per cycle while in_tready is high; its results are written into a
// four-entry result queue in the same cycle, and the queue drains one result per cycle
// while out_tready is high. A character that closes an op on the last position yields two
// results, so such a character takes two queue entries. in_tready is high while the queue
// has room for two results. Reset (rst_n low, synchronous) empties the queue and clears
// the length, op count and positions.
module cigar_text_to_binary_ops_with_bin (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // ch[7:0], start_pos[38:8], zero pad[39]
  input  logic        in_tuser,   // first
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata,  // op_word[31:0], op_count[47:32], bin[63:48],
                                  // end_pos[95:64]
  output logic        out_tuser,  // is_summary
  output logic        out_tlast   // last_of_run
);

  import cigar_pkg::*;

`include "assert_macros.svh"

  logic [27:0] len_r,   len_nxt;
  logic [30:0] start_r, start_nxt;
  logic [31:0] end_r,   end_nxt;
  logic [15:0] ops_r,   ops_nxt;

  res_t        q_mem [4];
  logic [1:0]  wr_ptr_r, rd_ptr_r;
  logic [2:0]  cnt_r, cnt_nxt;

  logic        in_acc, out_acc;
  logic [7:0]  ch;
  logic [30:0] sp;
  logic        first, last;
  logic [27:0] acc_base;
  logic [15:0] ops_base;
  logic [30:0] start_base;
  logic [31:0] end_base;
  logic        is_digit, lone_star, emit;
  logic [31:0] dig_sum;
  logic [27:0] dig_len;
  op_info_t    op;
  logic [32:0] end_sum;
  logic [31:0] end_op;
  logic [15:0] ops_op;
  res_t        res_op, res_sum, ent0;
  logic [1:0]  n_push;

  assign ch    = in_tdata[7:0];
  assign sp    = in_tdata[38:8];
  assign first = in_tuser;
  assign last  = in_tlast;

  assign in_tready  = (cnt_r <= 3'd2);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = (cnt_r != 3'd0);
  assign out_acc    = out_tvalid && out_tready;

  always_comb begin
    // a first character restarts the record before ch is handled
    acc_base   = first ? 28'd0 : len_r;
    ops_base   = first ? 16'd0 : ops_r;
    start_base = first ? sp : start_r;
    end_base   = first ? {1'b0, sp} : end_r;

    is_digit  = (ch >= CH_0) && (ch <= CH_9);
    lone_star = first && last && (ch == CH_STAR);
    emit      = !is_digit && !lone_star;

    // length * 10 + digit, saturating at 2^28-1
    dig_sum = {1'b0, acc_base, 3'b000} + {3'b000, acc_base, 1'b0} + {28'd0, ch[3:0]};
    dig_len = (dig_sum[31:28] != 4'd0) ? LEN_MAX : dig_sum[27:0];

    op      = op_decode(ch);
    end_sum = {1'b0, end_base} + {5'd0, acc_base};
    if (emit && op.adv) end_op = end_sum[32] ? 32'hFFFF_FFFF : end_sum[31:0];
    else                end_op = end_base;
    ops_op = emit ? ops_base + 16'd1 : ops_base;

    res_op.is_summary  = 1'b0;
    res_op.op_word     = {acc_base, 4'b0000} | {26'd0, op.code};
    res_op.op_count    = 16'd0;
    res_op.bin         = 16'd0;
    res_op.end_pos     = 32'd0;
    res_op.last_of_run = !last;

    res_sum.is_summary  = 1'b1;
    res_sum.op_word     = 32'd0;
    res_sum.op_count    = ops_op;
    res_sum.bin         = bin_of(start_base, end_op);
    res_sum.end_pos     = end_op;
    res_sum.last_of_run = 1'b1;

    ent0   = emit ? res_op : res_sum;
    n_push = in_acc ? ({1'b0, emit} + {1'b0, last}) : 2'd0;

    // pending digits are dropped at the end of a record
    if (last)          len_nxt = 28'd0;
    else if (is_digit) len_nxt = dig_len;
    else if (emit)     len_nxt = 28'd0;
    else               len_nxt = acc_base;
    ops_nxt   = last ? 16'd0 : ops_op;
    start_nxt = start_base;
    end_nxt   = end_op;

    cnt_nxt = cnt_r + {1'b0, n_push} - {2'd0, out_acc};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r    <= '0;
      start_r  <= '0;
      end_r    <= '0;
      ops_r    <= '0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (in_acc) begin
        len_r   <= len_nxt;
        start_r <= start_nxt;
        end_r   <= end_nxt;
        ops_r   <= ops_nxt;
      end
      wr_ptr_r <= wr_ptr_r + n_push;
      if (out_acc) rd_ptr_r <= rd_ptr_r + 2'd1;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) q_mem[wr_ptr_r] <= ent0;
    if (n_push == 2'd2) q_mem[wr_ptr_r + 2'd1] <= res_sum;
  end

  assign out_tdata = {q_mem[rd_ptr_r].end_pos, q_mem[rd_ptr_r].bin,
                      q_mem[rd_ptr_r].op_count, q_mem[rd_ptr_r].op_word};
  assign out_tuser = q_mem[rd_ptr_r].is_summary;
  assign out_tlast = q_mem[rd_ptr_r].last_of_run;

  `ASSERT_RST(a_cnt_ptrs, clk, rst_n, cnt_r[1:0] == wr_ptr_r - rd_ptr_r, "queue count and pointers disagree")
  `ASSERT_RST(a_cnt_max, clk, rst_n, cnt_r <= 3'd4, "result queue overflow")
  `ASSERT_RST(a_rec_clear, clk, rst_n, in_acc && in_tlast |=> len_r == 28'd0 && ops_r == 16'd0, "record state not cleared after last")
  `ASSERT_RST(a_sum_last, clk, rst_n, out_tvalid && out_tuser |-> out_tlast, "summary result not marked last of run")
  `ASSERT_RST(a_two_room, clk, rst_n, n_push == 2'd2 |-> cnt_r <= 3'd2, "two results pushed without room")

endmodule
